// File: src/srfr_pkg.sv
// Shared types and constants for the sensor reply frame receiver.
// No dependencies; the parser, top level and checker import this package.
package srfr_pkg;

  typedef enum logic [1:0] {
    CMD_RECV    = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_OK      = 3'd1,
    EV_BAD_SUM = 3'd2,
    EV_RESYNC  = 3'd3,
    EV_BAD_LEN = 3'd4,
    EV_IGNORED = 3'd5
  } event_e;

  // configuration register indexes
  localparam logic [1:0] CFG_HDR_HI = 2'd0;
  localparam logic [1:0] CFG_HDR_LO = 2'd1;
  localparam logic [1:0] CFG_ACK_ID = 2'd2;

  // configuration reset values
  localparam logic [7:0] HDR_HI_RST = 8'd239;
  localparam logic [7:0] HDR_LO_RST = 8'd1;
  localparam logic [7:0] ACK_ID_RST = 8'd7;

  typedef struct packed {
    logic [7:0] hdr_hi;
    logic [7:0] hdr_lo;
    logic [7:0] ack_id;
  } srfr_cfg_t;

  // per-item result from the frame parser
  typedef struct packed {
    event_e     evt;
    logic       packet_ready;
    logic [4:0] payload_count;
  } srfr_res_t;

endpackage

// File: src/srfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/srfr_parser.sv
// Receive state machine: header sync, address skip, id and length check,
// running checksum and buffer write requests. Depends on srfr_pkg.
module srfr_parser #(
  parameter int BUF_DEPTH  = 32,
  parameter int ADDR_BYTES = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   command_i,
  input  logic [7:0]                   data_byte_i,
  input  srfr_pkg::srfr_cfg_t          cfg_i,
  output srfr_pkg::srfr_res_t          res_o,
  output logic                         wr_en_o,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_addr_o,
  output logic [7:0]                   wr_data_o
);
  import srfr_pkg::*;

  localparam int CntMax = (BUF_DEPTH > ADDR_BYTES) ? BUF_DEPTH : ADDR_BYTES;
  localparam int IW     = $clog2(CntMax + 1);
  localparam int AW     = $clog2(BUF_DEPTH);

  typedef enum logic [2:0] {
    ST_HDR_HI,
    ST_HDR_LO,
    ST_ADDR,
    ST_PID,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DATA,
    ST_HELD
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   len_q, len_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      prev_q, prev_d;
  logic [4:0]      cnt_q, cnt_d;
  event_e          evt;
  logic            ready;
  logic [IW-1:0]   idx_inc;
  logic [15:0]     len_full;
  logic [15:0]     sum_add;

  assign idx_inc  = idx_q + IW'(1);
  assign len_full = {len_hi_q, data_byte_i};
  assign sum_add  = sum_q + 16'(data_byte_i);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    len_d    = len_q;
    len_hi_d = len_hi_q;
    sum_d    = sum_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    evt      = EV_NONE;
    ready    = 1'b0;
    wr_en_o  = 1'b0;
    if (accept_i) begin
      case (command_i)
        CMD_RECV: begin
          case (state_q)
            ST_HDR_HI: begin
              if (data_byte_i == cfg_i.hdr_hi) begin
                state_d = ST_HDR_LO;
              end
            end
            ST_HDR_LO: begin
              idx_d = '0;
              if (data_byte_i == cfg_i.hdr_lo) begin
                state_d = (ADDR_BYTES == 0) ? ST_PID : ST_ADDR;
              end else begin
                state_d = ST_HDR_HI;
                evt     = EV_RESYNC;
              end
            end
            ST_ADDR: begin
              idx_d = idx_inc;
              if (32'(idx_inc) >= ADDR_BYTES) begin
                idx_d   = '0;
                state_d = ST_PID;
              end
            end
            ST_PID: begin
              if (data_byte_i == cfg_i.ack_id) begin
                sum_d   = 16'(data_byte_i);
                state_d = ST_LEN_HI;
              end else begin
                state_d = ST_HDR_HI;
                idx_d   = '0;
                evt     = EV_RESYNC;
              end
            end
            ST_LEN_HI: begin
              len_hi_d = data_byte_i;
              sum_d    = sum_add;
              state_d  = ST_LEN_LO;
            end
            ST_LEN_LO: begin
              sum_d = sum_add;
              idx_d = '0;
              if ((len_full < 16'd2) || (32'(len_full) > BUF_DEPTH)) begin
                state_d = ST_HDR_HI;
                evt     = EV_BAD_LEN;
              end else begin
                len_d   = IW'(len_full);
                state_d = ST_DATA;
              end
            end
            ST_DATA: begin
              wr_en_o = 1'b1;
              prev_d  = data_byte_i;
              // checksum bytes themselves stay out of the sum
              if ((32'(idx_q) + 2) < 32'(len_q)) begin
                sum_d = sum_add;
              end
              idx_d = idx_inc;
              if (idx_inc >= len_q) begin
                idx_d = '0;
                if ({prev_q, data_byte_i} == sum_q) begin
                  cnt_d   = 5'(len_q - IW'(2));
                  state_d = ST_HELD;
                  evt     = EV_OK;
                end else begin
                  state_d = ST_HDR_HI;
                  evt     = EV_BAD_SUM;
                end
              end
            end
            default: begin
              evt = EV_IGNORED;
            end
          endcase
        end
        CMD_CONSUME: begin
          if (state_q == ST_HELD) begin
            state_d = ST_HDR_HI;
            idx_d   = '0;
            ready   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign wr_addr_o           = AW'(idx_q);
  assign wr_data_o           = data_byte_i;
  assign res_o.evt           = evt;
  assign res_o.packet_ready  = ready;
  assign res_o.payload_count = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HDR_HI;
      idx_q    <= '0;
      len_q    <= '0;
      len_hi_q <= '0;
      sum_q    <= '0;
      prev_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      len_hi_q <= len_hi_d;
      sum_q    <= sum_d;
      prev_q   <= prev_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: src/sensor_reply_frame_receiver_core.sv
// Top level of the sensor reply frame receiver: configuration registers,
// parser, frame buffer RAM and output pipeline. Depends on srfr_pkg,
// srfr_parser and srfr_ram.
//
// Pipeline: two register stages, stage 1 and the output register; a result moves
// between them when stage 1 advances. Throughput: one item per cycle while in_stall_o
// is low; the buffer RAM takes one write and one read a cycle.
// Reset clears the receive state, counters, pipeline valids and config registers;
// the frame buffer is not cleared and holds whatever it held until written.
module sensor_reply_frame_receiver_core #(
  parameter int BUF_DEPTH  = 32,
  parameter int ADDR_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input item channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic [4:0] read_index_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic       packet_ready_o,
  output logic [7:0] read_data_o,
  output logic [4:0] payload_count_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import srfr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  srfr_cfg_t  cfg_q;
  srfr_res_t  res;
  logic       in_xfer;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_data;
  logic       rd_hit;
  logic [7:0] ram_rdata;

  // stage 1: item accepted, RAM read in flight
  logic       p1_valid_q;
  srfr_res_t  p1_res_q;
  logic       p1_read_q;
  logic       p1_adv;

  // stage 2: output register
  logic       o_valid_q;
  srfr_res_t  o_res_q;
  logic [7:0] o_rdata_q;
  logic       o_take;

  // Config is always writable; the user only writes while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_hi <= HDR_HI_RST;
      cfg_q.hdr_lo <= HDR_LO_RST;
      cfg_q.ack_id <= ACK_ID_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HDR_HI: cfg_q.hdr_hi <= cfg_data_i;
        CFG_HDR_LO: cfg_q.hdr_lo <= cfg_data_i;
        CFG_ACK_ID: cfg_q.ack_id <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Handshake. Stage 1 advances when the output register is empty or drains;
  // stall only when both stages hold results and the sink is stalling.
  assign o_take     = o_valid_q & ~out_stall_i;
  assign p1_adv     = p1_valid_q & (~o_valid_q | ~out_stall_i);
  assign in_stall_o = p1_valid_q & o_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  srfr_parser #(
    .BUF_DEPTH (BUF_DEPTH),
    .ADDR_BYTES(ADDR_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_xfer),
    .command_i  (command_i),
    .data_byte_i(data_byte_i),
    .cfg_i      (cfg_q),
    .res_o      (res),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Read only in-range indexes; out-of-range reads answer zero.
  assign rd_hit = (command_i == CMD_READ) && (32'(read_index_i) < BUF_DEPTH);

  // A read issued here sees every write of earlier transfers, since a write
  // lands at its own transfer edge; the read word holds while stage 1 waits
  // because no new read is issued until stage 1 advances.
  srfr_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (in_xfer & rd_hit),
    .raddr_i(AW'(read_index_i)),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        p1_valid_q <= 1'b1;
      end else if (p1_adv) begin
        p1_valid_q <= 1'b0;
      end
      if (p1_adv) begin
        o_valid_q <= 1'b1;
      end else if (o_take) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p1_res_q  <= res;
      p1_read_q <= rd_hit;
    end
    if (p1_adv) begin
      o_res_q   <= p1_res_q;
      o_rdata_q <= p1_read_q ? ram_rdata : 8'd0;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign event_res_o     = o_res_q.evt;
  assign packet_ready_o  = o_res_q.packet_ready;
  assign read_data_o     = o_rdata_q;
  assign payload_count_o = o_res_q.payload_count;

endmodule

// File: src/srfr_checker.sv
// Port-level checks for the sensor reply frame receiver, bound to the top level.
// Depends on srfr_pkg and sensor_reply_frame_receiver_core.
module srfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] event_res_o,
  input logic       packet_ready_o,
  input logic [7:0] read_data_o,
  input logic [4:0] payload_count_o
);
  import srfr_pkg::*;

  // event codes stay within the defined set
  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o <= EV_IGNORED))
    else $error("event code out of range");

  // a receive event, a release and read data never come from the same item
  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_res_o == EV_NONE) || (!packet_ready_o && read_data_o == 8'd0))
                    && (!packet_ready_o || read_data_o == 8'd0))
    else $error("result fields of different commands mixed");

  // input stalls only while a finished result waits on a stalled sink
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(event_res_o)
      && $stable(packet_ready_o) && $stable(read_data_o) && $stable(payload_count_o)))
    else $error("stalled result changed");

endmodule

bind sensor_reply_frame_receiver_core srfr_checker u_srfr_checker (.*);
